>>> hw/rtl/sem_pkg.sv
// shared types, constants and kernel tables for the sobel edge magnitude core
// no dependencies; imported by sem_ctrl, sem_dp and the top level
package sem_pkg;

  localparam int CfgDataW = 16;
  localparam int WidthRegW = 11;
  localparam int HeightW = 16;
  localparam int ChW = 8;
  localparam int PixW = 3 * ChW;
  localparam int GradW = 11;
  localparam int SumW = 24;
  localparam int NumTaps = 9;

  // register indexes
  localparam logic [0:0] RegImageWidth = 1'b0;
  localparam logic [0:0] RegImageHeight = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic       we;
    logic       wr_held;
    logic       pix_ld;
    logic [1:0] wr_bank;
    logic       rd_en;
    logic [1:0] rd_bank;
    logic       acc_clr;
    logic       acc_en;
    logic       acc_zero;
    logic [3:0] acc_tap;
    logic       sq_en;
    logic       root_en;
    logic [2:0] root_bit;
    logic       out_load;
    logic       out_fe;
  } sem_cmd_t;

  // window row of a tap (0 = upper)
  function automatic logic [1:0] tap_dr(input logic [3:0] tap);
    logic [1:0] r;
    case (tap)
      4'd0, 4'd1, 4'd2: r = 2'd0;
      4'd3, 4'd4, 4'd5: r = 2'd1;
      default: r = 2'd2;
    endcase
    return r;
  endfunction

  // window column of a tap (0 = left)
  function automatic logic [1:0] tap_dc(input logic [3:0] tap);
    logic [1:0] c;
    case (tap)
      4'd0, 4'd3, 4'd6: c = 2'd0;
      4'd1, 4'd4, 4'd7: c = 2'd1;
      default: c = 2'd2;
    endcase
    return c;
  endfunction

  // horizontal kernel coefficient
  function automatic logic signed [2:0] kern_x(input logic [3:0] tap);
    logic signed [2:0] k;
    case (tap)
      4'd0, 4'd6: k = -3'sd1;
      4'd2, 4'd8: k = 3'sd1;
      4'd3: k = -3'sd2;
      4'd5: k = 3'sd2;
      default: k = 3'sd0;
    endcase
    return k;
  endfunction

  // vertical kernel coefficient
  function automatic logic signed [2:0] kern_y(input logic [3:0] tap);
    logic signed [2:0] k;
    case (tap)
      4'd0, 4'd2: k = -3'sd1;
      4'd1: k = -3'sd2;
      4'd6, 4'd8: k = 3'sd1;
      4'd7: k = 3'sd2;
      default: k = 3'sd0;
    endcase
    return k;
  endfunction

endpackage

>>> hw/rtl/sobel_edge_magnitude_rgb_core.sv
// sobel edge magnitude core: pixel stream in, per-channel gradient magnitude out
// a pixel that yields no result leaves the core idle; one with a result passes
// through accept, 9 tap reads plus a final accumulate, the square, 8 root bits and
// the output load, and waits longer while the previous result waits on the output
// results lag the input by one row plus one pixel; drain items flush the rest
// reset: width 640, height 480, counters cleared; row memories are not cleared
// depends on sem_pkg, sem_ctrl, sem_dp
module sobel_edge_magnitude_rgb_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [0:0]                    cfg_idx_i,
  input  logic [sem_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [sem_pkg::PixW-1:0]      s_axis_tdata,  // red, green, blue
  input  logic                          s_axis_tuser,  // action
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [sem_pkg::PixW-1:0]      m_axis_tdata,  // edge_red, edge_green, edge_blue
  output logic                          m_axis_tlast   // frame_end
);
  import sem_pkg::*;

  localparam int ColW = $clog2(MAX_WIDTH);

  sem_cmd_t        cmd;
  logic [ColW-1:0] wr_col, rd_col;

  // controller
  sem_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_drain_i (s_axis_tuser),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .wr_col_o   (wr_col),
    .rd_col_o   (rd_col),
    .cmd_o      (cmd)
  );

  // datapath
  sem_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk_i   (clk_i),
    .cmd_i   (cmd),
    .wr_col_i(wr_col),
    .rd_col_i(rd_col),
    .pix_i   (s_axis_tdata),
    .edge_o  (m_axis_tdata),
    .fe_o    (m_axis_tlast)
  );

endmodule

>>> hw/rtl/sem_ctrl.sv
// controller: frame counters, config registers, tap sequencer and output handshake
// depends on sem_pkg
module sem_ctrl #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [0:0]                    cfg_idx_i,
  input  logic [sem_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          in_drain_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [$clog2(MAX_WIDTH)-1:0]  wr_col_o,
  output logic [$clog2(MAX_WIDTH)-1:0]  rd_col_o,
  output sem_pkg::sem_cmd_t             cmd_o
);
  import sem_pkg::*;

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int WcW = $clog2(MAX_WIDTH + 1);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRead = 3'd1;
  localparam logic [2:0] StSqr  = 3'd2;
  localparam logic [2:0] StRoot = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0]           state_q, state_d;
  logic [WidthRegW-1:0] width_q, width_d;
  logic [HeightW-1:0]   height_q, height_d;
  logic [ColW-1:0]      in_col_q, in_col_d;
  logic [HeightW-1:0]   in_row_q, in_row_d;
  logic [1:0]           in_slot_q, in_slot_d;
  logic [ColW-1:0]      out_col_q, out_col_d;
  logic [HeightW-1:0]   out_row_q, out_row_d;
  logic [1:0]           out_slot_q, out_slot_d;
  logic [ColW-1:0]      o_col_q, o_col_d;
  logic [HeightW-1:0]   o_row_q, o_row_d;
  logic [1:0]           o_slot_q, o_slot_d;
  logic                 o_fe_q, o_fe_d;
  logic [ColW-1:0]      w_col_q, w_col_d;
  logic [1:0]           w_slot_q, w_slot_d;
  logic                 w_pend_q, w_pend_d;
  logic [3:0]           tap_cnt_q, tap_cnt_d;
  logic [3:0]           tap_q, tap_d;
  logic                 tap_ok_q, tap_ok_d;
  logic [2:0]           bit_q, bit_d;
  logic                 mv_q, mv_d;

  logic [WcW-1:0]       eff_w;
  logic [HeightW-1:0]   eff_h;

  // effective frame size
  always_comb begin
    if (width_q == '0) begin
      eff_w = WcW'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      eff_w = WcW'(MAX_WIDTH);
    end else begin
      eff_w = WcW'(width_q);
    end
    eff_h = (height_q == '0) ? HeightW'(1) : height_q;
  end

  function automatic logic [1:0] slot_inc(input logic [1:0] s);
    return (s == 2'd2) ? 2'd0 : s + 2'd1;
  endfunction

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = mv_q;

  // sequencer
  always_comb begin
    logic            wrap, produce, drain_ok;
    logic [ColW-1:0] cc;
    logic [HeightW-1:0] cr;
    logic [1:0]      cs;
    logic [1:0]      dr, dc;
    logic            row_ok, col_ok;

    state_d    = state_q;
    width_d    = width_q;
    height_d   = height_q;
    in_col_d   = in_col_q;
    in_row_d   = in_row_q;
    in_slot_d  = in_slot_q;
    out_col_d  = out_col_q;
    out_row_d  = out_row_q;
    out_slot_d = out_slot_q;
    o_col_d    = o_col_q;
    o_row_d    = o_row_q;
    o_slot_d   = o_slot_q;
    o_fe_d     = o_fe_q;
    w_col_d    = w_col_q;
    w_slot_d   = w_slot_q;
    w_pend_d   = w_pend_q;
    tap_cnt_d  = tap_cnt_q;
    tap_d      = tap_q;
    tap_ok_d   = tap_ok_q;
    bit_d      = bit_q;
    mv_d       = mv_q;
    cmd_o      = '0;
    wr_col_o   = '0;
    rd_col_o   = '0;
    produce    = 1'b0;

    if (mv_q && out_ready_i) begin
      mv_d = 1'b0;
    end

    wrap     = (in_row_q >= eff_h);
    cc       = wrap ? '0 : in_col_q;
    cr       = wrap ? '0 : in_row_q;
    cs       = wrap ? 2'd0 : in_slot_q;
    drain_ok = wrap && (out_row_q < eff_h);

    dr = tap_dr(tap_cnt_q);
    dc = tap_dc(tap_cnt_q);
    row_ok = !(dr == 2'd0 && o_row_q == '0) &&
             !(dr == 2'd2 && ({1'b0, o_row_q} + 17'd1) >= {1'b0, eff_h});
    col_ok = !(dc == 2'd0 && o_col_q == '0) &&
             !(dc == 2'd2 && (WcW'(o_col_q) + WcW'(1)) >= eff_w);

    case (state_q)
      StIdle: begin
        if (in_valid_i && !in_drain_i) begin
          // pixel: write into its row slot and advance input position
          produce = (cr >= HeightW'(2)) || (cr == HeightW'(1) && cc != '0);
          // a pixel that yields a result is held and written after the upper row reads
          cmd_o.we      = !produce;
          cmd_o.pix_ld  = produce;
          cmd_o.wr_bank = cs;
          wr_col_o      = cc;
          w_col_d       = cc;
          w_slot_d      = cs;
          w_pend_d      = produce;
          if (wrap) begin
            out_col_d  = '0;
            out_row_d  = '0;
            out_slot_d = 2'd0;
          end
          if ((WcW'(cc) + WcW'(1)) >= eff_w) begin
            in_col_d  = '0;
            in_row_d  = cr + HeightW'(1);
            in_slot_d = slot_inc(cs);
          end else begin
            in_col_d  = cc + ColW'(1);
            in_row_d  = cr;
            in_slot_d = cs;
          end
        end else if (in_valid_i && in_drain_i) begin
          produce  = drain_ok;
          w_pend_d = 1'b0;
        end
        if (produce) begin
          // latch the output position (counters are zero after a wrap)
          o_col_d  = wrap && !in_drain_i ? '0 : out_col_q;
          o_row_d  = wrap && !in_drain_i ? '0 : out_row_q;
          o_slot_d = wrap && !in_drain_i ? 2'd0 : out_slot_q;
          o_fe_d   = (o_row_d == eff_h - HeightW'(1)) &&
                     ((WcW'(o_col_d) + WcW'(1)) == eff_w);
          if ((WcW'(o_col_d) + WcW'(1)) >= eff_w) begin
            out_col_d  = '0;
            out_row_d  = o_row_d + HeightW'(1);
            out_slot_d = slot_inc(o_slot_d);
          end else begin
            out_col_d  = o_col_d + ColW'(1);
            out_row_d  = o_row_d;
            out_slot_d = o_slot_d;
          end
          cmd_o.acc_clr = 1'b1;
          tap_cnt_d     = '0;
          state_d       = StRead;
        end
      end
      StRead: begin
        // issue one tap read a cycle, accumulate the previous tap
        if (tap_cnt_q < 4'(NumTaps)) begin
          cmd_o.rd_en = row_ok && col_ok;
          case (dr)
            2'd0: cmd_o.rd_bank = slot_inc(slot_inc(o_slot_q));
            2'd1: cmd_o.rd_bank = o_slot_q;
            default: cmd_o.rd_bank = slot_inc(o_slot_q);
          endcase
          rd_col_o = o_col_q + ColW'(dc) - ColW'(1);
          tap_d    = tap_cnt_q;
          tap_ok_d = row_ok && col_ok;
        end
        // held pixel goes in once the upper row taps are read, before the lower right tap
        if (tap_cnt_q == 4'd3 && w_pend_q) begin
          cmd_o.we      = 1'b1;
          cmd_o.wr_held = 1'b1;
          cmd_o.wr_bank = w_slot_q;
          wr_col_o      = w_col_q;
        end
        if (tap_cnt_q != '0) begin
          cmd_o.acc_en   = 1'b1;
          cmd_o.acc_tap  = tap_q;
          cmd_o.acc_zero = !tap_ok_q;
        end
        if (tap_cnt_q == 4'(NumTaps)) begin
          state_d = StSqr;
        end else begin
          tap_cnt_d = tap_cnt_q + 4'd1;
        end
      end
      StSqr: begin
        cmd_o.sq_en = 1'b1;
        bit_d       = 3'd7;
        state_d     = StRoot;
      end
      StRoot: begin
        // one result bit a cycle
        cmd_o.root_en  = 1'b1;
        cmd_o.root_bit = bit_q;
        if (bit_q == 3'd0) begin
          state_d = StOut;
        end else begin
          bit_d = bit_q - 3'd1;
        end
      end
      StOut: begin
        if (!mv_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_fe   = o_fe_q;
          mv_d           = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase

    // config write restarts the frame
    if (cfg_we_i) begin
      if (cfg_idx_i == RegImageWidth) begin
        width_d = cfg_data_i[WidthRegW-1:0];
      end else begin
        height_d = cfg_data_i[HeightW-1:0];
      end
      in_col_d   = '0;
      in_row_d   = '0;
      in_slot_d  = 2'd0;
      out_col_d  = '0;
      out_row_d  = '0;
      out_slot_d = 2'd0;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      width_q    <= WidthRegW'(640);
      height_q   <= HeightW'(480);
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_slot_q  <= 2'd0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_slot_q <= 2'd0;
      tap_cnt_q  <= '0;
      bit_q      <= '0;
      mv_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      width_q    <= width_d;
      height_q   <= height_d;
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      in_slot_q  <= in_slot_d;
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
      out_slot_q <= out_slot_d;
      tap_cnt_q  <= tap_cnt_d;
      bit_q      <= bit_d;
      mv_q       <= mv_d;
    end
  end

  // position of the item at work
  always_ff @(posedge clk_i) begin
    o_col_q  <= o_col_d;
    o_row_q  <= o_row_d;
    o_slot_q <= o_slot_d;
    o_fe_q   <= o_fe_d;
    w_col_q  <= w_col_d;
    w_slot_q <= w_slot_d;
    w_pend_q <= w_pend_d;
    tap_q    <= tap_d;
    tap_ok_q <= tap_ok_d;
  end

endmodule

>>> hw/rtl/sem_dp.sv
// datapath: three row memories, sobel accumulators, squares and bit-serial root
// depends on sem_pkg
module sem_dp #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk_i,
  input  sem_pkg::sem_cmd_t             cmd_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]  wr_col_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]  rd_col_i,
  input  logic [sem_pkg::PixW-1:0]      pix_i,
  output logic [sem_pkg::PixW-1:0]      edge_o,
  output logic                          fe_o
);
  import sem_pkg::*;

  localparam int ColW = $clog2(MAX_WIDTH);

  logic [PixW-1:0] mem0 [MAX_WIDTH];
  logic [PixW-1:0] mem1 [MAX_WIDTH];
  logic [PixW-1:0] mem2 [MAX_WIDTH];
  logic [PixW-1:0] rd_q;
  logic [PixW-1:0] pix_q;
  logic [PixW-1:0] wr_data;

  logic signed [GradW-1:0] gx_q [3];
  logic signed [GradW-1:0] gy_q [3];
  logic [SumW-1:0]         four_s_q [3];
  logic [ChW-1:0]          k_q [3];
  logic [PixW-1:0]         edge_q;
  logic                    fe_q;

  // held pixel for a deferred write
  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_ld) begin
      pix_q <= pix_i;
    end
  end

  assign wr_data = cmd_i.wr_held ? pix_q : pix_i;

  // row memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      case (cmd_i.wr_bank)
        2'd0: mem0[wr_col_i] <= wr_data;
        2'd1: mem1[wr_col_i] <= wr_data;
        default: mem2[wr_col_i] <= wr_data;
      endcase
    end
    if (cmd_i.rd_en) begin
      case (cmd_i.rd_bank)
        2'd0: rd_q <= mem0[rd_col_i];
        2'd1: rd_q <= mem1[rd_col_i];
        default: rd_q <= mem2[rd_col_i];
      endcase
    end
  end

  // accumulate, square and root per channel
  always_ff @(posedge clk_i) begin
    for (int ch = 0; ch < 3; ch++) begin
      logic signed [GradW-1:0] v, cx, cy;
      logic signed [22:0]      sx, sy;
      logic [ChW-1:0]          t;
      logic [ChW:0]            d;
      logic [17:0]             dd;
      v  = cmd_i.acc_zero ? '0 : signed'({3'b000, rd_q[ch*ChW +: ChW]});
      cx = GradW'(kern_x(cmd_i.acc_tap));
      cy = GradW'(kern_y(cmd_i.acc_tap));
      sx = 23'(gx_q[ch]) * 23'(gx_q[ch]);
      sy = 23'(gy_q[ch]) * 23'(gy_q[ch]);
      t  = k_q[ch] | (ChW'(1) << cmd_i.root_bit);
      d  = {t, 1'b0} - (ChW+1)'(1);
      dd = 18'(d) * 18'(d);
      if (cmd_i.acc_clr) begin
        gx_q[ch] <= '0;
        gy_q[ch] <= '0;
      end else if (cmd_i.acc_en) begin
        gx_q[ch] <= gx_q[ch] + v * cx;
        gy_q[ch] <= gy_q[ch] + v * cy;
      end
      if (cmd_i.sq_en) begin
        four_s_q[ch] <= {sx[21:0] + sy[21:0], 2'b00};
        k_q[ch]      <= '0;
      end else if (cmd_i.root_en) begin
        if ({6'b0, dd} <= four_s_q[ch]) begin
          k_q[ch] <= t;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      edge_q <= {k_q[2], k_q[1], k_q[0]};
      fe_q   <= cmd_i.out_fe;
    end
  end

  assign edge_o = edge_q;
  assign fe_o   = fe_q;

endmodule

>>> test/tb_sobel_edge_magnitude_rgb_core.sv
// testbench for sobel_edge_magnitude_rgb_core: random and directed rgb frames,
// per-channel edge magnitudes predicted in-bench and checked item by item
// depends on sem_pkg and the core rtl only
`timescale 1ns / 100ps

module tb_sobel_edge_magnitude_rgb_core;
  import sem_pkg::*;

  localparam int MaxW = 1024;
  localparam int LatencyCycles = 60;
  localparam longint CycleLimit = 3000000;

  typedef struct packed {
    logic [7:0] mag_r;
    logic [7:0] mag_g;
    logic [7:0] mag_b;
    logic       frame_end;
  } edge_px_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [0:0] cfg_idx_i = RegImageWidth;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [PixW-1:0] s_axis_tdata = '0;  // red, green, blue
  logic s_axis_tuser = 1'b0;  // action
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [PixW-1:0] m_axis_tdata;  // edge_red, edge_green, edge_blue
  logic m_axis_tlast;  // frame_end

  sobel_edge_magnitude_rgb_core #(.MAX_WIDTH(MaxW)) DUT (.*);

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state: three row slots plus stream counters
  logic [23:0] row_slots [3][MaxW];
  int unsigned img_w_q = 640, img_h_q = 480;
  int unsigned in_col_q, in_row_q, out_idx_q;
  edge_px_t edge_q[$];
  int mismatches = 0;
  int send_idle_pct = 0, recv_stall_pct = 0;
  longint cycles = 0;

  function automatic int unsigned eff_width();
    if (img_w_q < 1) return 1;
    if (img_w_q > MaxW) return MaxW;
    return img_w_q;
  endfunction

  function automatic int unsigned eff_height();
    return (img_h_q < 1) ? 1 : img_h_q;
  endfunction

  // rounded square root, clamped to 255
  function automatic logic [7:0] round_root(int unsigned s);
    int unsigned k, t, d;
    k = 0;
    for (int b = 128; b != 0; b >>= 1) begin
      t = k | b;
      d = 2 * t - 1;
      if (d * d <= 4 * s) k = t;
    end
    return k[7:0];
  endfunction

  // neighbour pixel, zero outside the frame; the pixel in flight comes from pix_in
  function automatic logic [23:0] window_px(int r, int c, bit has_in, int now,
                                            logic [23:0] pix_in);
    int w, h;
    w = eff_width();
    h = eff_height();
    if (r < 0 || r >= h || c < 0 || c >= w) return '0;
    if (has_in && r * w + c == now) return pix_in;
    return row_slots[r % 3][c];
  endfunction

  function automatic edge_px_t sobel_at(int unsigned k, bit has_in, int now,
                                        logic [23:0] pix_in);
    int kx[9] = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
    int ky[9] = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};
    int gx[3], gy[3], w, orow, ocol, v;
    logic [23:0] p;
    logic [7:0] mag[3];
    edge_px_t e;
    w = eff_width();
    orow = k / w;
    ocol = k % w;
    gx = '{0, 0, 0};
    gy = '{0, 0, 0};
    for (int t = 0; t < 9; t++) begin
      p = window_px(orow + t / 3 - 1, ocol + t % 3 - 1, has_in, now, pix_in);
      for (int ch = 0; ch < 3; ch++) begin
        v = (p >> (16 - 8 * ch)) & 255;
        gx[ch] += kx[t] * v;
        gy[ch] += ky[t] * v;
      end
    end
    for (int ch = 0; ch < 3; ch++) mag[ch] = round_root(gx[ch] * gx[ch] + gy[ch] * gy[ch]);
    e.mag_r = mag[0];
    e.mag_g = mag[1];
    e.mag_b = mag[2];
    e.frame_end = (k == eff_width() * eff_height() - 1);
    return e;
  endfunction

  // advance the predictor by one accepted item
  task automatic predict_item(logic action, logic [23:0] pix);
    int unsigned w, h, n;
    w = eff_width();
    h = eff_height();
    if (!action) begin
      if (in_row_q >= h) begin
        in_row_q = 0;
        in_col_q = 0;
        out_idx_q = 0;
      end
      n = in_row_q * w + in_col_q;
      if (n >= w + 1) begin
        edge_q.push_back(sobel_at(out_idx_q, 1'b1, n, pix));
        out_idx_q++;
      end
      row_slots[in_row_q % 3][in_col_q] = pix;
      in_col_q++;
      if (in_col_q >= w) begin
        in_col_q = 0;
        in_row_q++;
      end
    end else if (in_row_q >= h && out_idx_q < w * h) begin
      edge_q.push_back(sobel_at(out_idx_q, 1'b0, 0, '0));
      out_idx_q++;
    end
  endtask

  // send one item and update the prediction once it is accepted
  task automatic send_item(logic action, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= action;
    s_axis_tdata <= {b, g, r};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_item(action, {r, g, b});
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (edge_q.size() != 0) @(posedge clk_i);
    repeat (LatencyCycles) @(posedge clk_i);
  endtask

  // register write while idle; restarts the frame
  task automatic write_reg(logic [0:0] idx, logic [CfgDataW-1:0] val);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegImageWidth) img_w_q = val & 16'h07FF;
    else img_h_q = val;
    in_col_q = 0;
    in_row_q = 0;
    out_idx_q = 0;
  endtask

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return $urandom_range(255);
    endcase
  endfunction

  task automatic send_pixel();
    send_item(1'b0, rand_chan(), rand_chan(), rand_chan());
  endtask

  task automatic send_drain();
    send_item(1'b1, $urandom_range(255), $urandom_range(255), $urandom_range(255));
  endtask

  // one frame of random pixels followed by drain items
  task automatic run_frame(int unsigned npix, int unsigned ndrain);
    for (int i = 0; i < npix; i++) begin
      if ($urandom_range(30) == 0) send_drain();  // early drain; ignored unless the last frame is unflushed
      send_pixel();
    end
    repeat (ndrain) send_drain();
  endtask

  task automatic test_directed();
    write_reg(RegImageWidth, 3);
    write_reg(RegImageHeight, 3);
    // extremes and a checkerboard
    for (int i = 0; i < 9; i++) begin
      if (i == 4) send_item(1'b1, 8'hFF, 8'hFF, 8'hFF);
      if (i % 2) send_item(1'b0, 8'hFF, 8'h00, 8'hFF);
      else send_item(1'b0, 8'h00, 8'hFF, 8'h00);
    end
    repeat (6) send_item(1'b1, 8'h00, 8'h00, 8'h00);  // four flush the rest of the frame, the extra two are ignored
    // pixels of a new frame arrive before the old one is drained
    repeat (9) send_item(1'b0, 8'hFF, 8'hFF, 8'hFF);
    send_drain();
    repeat (4) send_pixel();
    // width and height zero act as one
    write_reg(RegImageWidth, 0);
    write_reg(RegImageHeight, 0);
    send_pixel();
    send_drain();
    send_drain();
    send_pixel();
    send_pixel();
  endtask

  task automatic test_size_extremes();
    // width above the maximum, single row; only a few results drained, the
    // rest is dropped by the next register write
    write_reg(RegImageWidth, 16'h07FF);
    write_reg(RegImageHeight, 1);
    repeat (MaxW) send_pixel();
    repeat (4) send_drain();
    // tallest frame, only its first rows sent
    write_reg(RegImageWidth, 2);
    write_reg(RegImageHeight, 16'hFFFF);
    run_frame(30, 2);
    write_reg(RegImageWidth, 1);
    run_frame(20, 1);
  endtask

  task automatic test_random(int unsigned budget);
    int unsigned sent, w, h, nd;
    sent = 0;
    while (sent < budget) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
      h = $urandom_range(8, 1);
      write_reg(RegImageWidth, w);
      write_reg(RegImageHeight, h);
      repeat ($urandom_range(3, 1)) begin
        nd = (w * h < w + 1) ? w * h : w + 1;
        case ($urandom_range(9))
          0: nd = $urandom_range(nd);  // cut short
          1: nd = nd + $urandom_range(3);  // surplus drains
          default: ;
        endcase
        run_frame(w * h, nd);
        sent += w * h + nd;
      end
    end
  endtask

  // receiver stalls
  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

  // result checker
  always @(posedge clk_i) begin
    edge_px_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16], m_axis_tlast};
      if (edge_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item %h", got);
      end else begin
        want = edge_q.pop_front();
        if (got.mag_r !== want.mag_r || got.mag_g !== want.mag_g ||
            got.mag_b !== want.mag_b || got.frame_end !== want.frame_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected r=%0d g=%0d b=%0d last=%0d, got r=%0d g=%0d b=%0d last=%0d",
                     want.mag_r, want.mag_g, want.mag_b, want.frame_end,
                     got.mag_r, got.mag_g, got.mag_b, got.frame_end);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_size_extremes();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random(30);
    send_idle_pct = 47;
    test_random(30);
    send_idle_pct = 0;
    recv_stall_pct = 47;
    test_random(30);
    send_idle_pct = 29;
    recv_stall_pct = 29;
    test_random(30);
    wait_idle();
    if (mismatches == 0 && edge_q.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
